### design/generalized_collatz_orbit_engine_unit_macros.svh
// Assertion macros used by the orbit engine controller.
`ifndef GENERALIZED_COLLATZ_ORBIT_ENGINE_UNIT_MACROS_SVH
`define GENERALIZED_COLLATZ_ORBIT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCOE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCOE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gcoe_pkg.sv
// Package with constants, codes and control types of the orbit engine.
package gcoe_pkg;

  localparam int XW          = 128;
  localparam int SEED_W      = 64;
  localparam int COEF_W      = 24;
  localparam int CNT_W       = 32;
  localparam int CTR_W       = 50;
  localparam int RES_W       = 5;
  localparam int DIV_W       = 6;
  localparam int HEIGHT_W    = 7;
  localparam int ESCAPE_BITS = 100;
  localparam int MAX_MODULUS = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EVEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ODD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP    = 3'd4;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Outcome codes.
  localparam logic [1:0] OUT_DROPPED = 2'd0;
  localparam logic [1:0] OUT_ESCAPED = 2'd1;
  localparam logic [1:0] OUT_CAPPED  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic div_init;
    logic div_step;
    logic rd;
    logic mul_step;
    logic upd;
    logic h_init;
    logic h_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escaped;
    logic done;
    logic div_last;
    logic mul_last;
    logic h_stop;
  } status_t;

endpackage

### design/gcoe_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface gcoe_in_if import gcoe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [RES_W-1:0]    residue_index;
  logic [COEF_W-1:0]   mult_coeff;
  logic [COEF_W-1:0]   add_coeff;
  logic [SEED_W-1:0]   seed;

  modport source (output valid, opcode, residue_index, mult_coeff, add_coeff, seed,
                  input ready);
  modport sink (input valid, opcode, residue_index, mult_coeff, add_coeff, seed,
                output ready);
endinterface

interface gcoe_out_if import gcoe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          outcome;
  logic [CNT_W-1:0]    drop_step;
  logic                boundary_hit;
  logic [CNT_W-1:0]    hit_step;
  logic [HEIGHT_W-1:0] height;
  logic [CNT_W-1:0]    odd_count;
  logic [CNT_W-1:0]    step_count;

  modport source (output valid, outcome, drop_step, boundary_hit, hit_step, height,
                  odd_count, step_count, input ready);
  modport sink (input valid, outcome, drop_step, boundary_hit, hit_step, height,
                odd_count, step_count, output ready);
endinterface

### design/gcoe_datapath.sv
// Datapath: configuration, coefficient memory, divider, multiplier, statistics and height search.
module gcoe_datapath import gcoe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [RES_W-1:0]      residue_index,
  input  logic [COEF_W-1:0]     mult_coeff,
  input  logic [COEF_W-1:0]     add_coeff,
  input  logic [SEED_W-1:0]     seed,
  input  cmd_t                  cmd,
  output status_t               st,
  output logic [1:0]            outcome,
  output logic [CNT_W-1:0]      drop_step,
  output logic                  boundary_hit,
  output logic [CNT_W-1:0]      hit_step,
  output logic [HEIGHT_W-1:0]   height,
  output logic [CNT_W-1:0]      odd_count,
  output logic [CNT_W-1:0]      step_count
);

  // Configuration registers.
  logic [DIV_W-1:0]  modulus;
  logic [15:0]       weight_even;
  logic [15:0]       weight_odd;
  logic [CNT_W-1:0]  boundary;
  logic [CNT_W-1:0]  step_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= DIV_W'(2);
      weight_even <= 16'd2;
      weight_odd  <= 16'hFFFF;
      boundary    <= CNT_W'(1);
      step_cap    <= CNT_W'(1000000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:     modulus     <= cfg_data[DIV_W-1:0];
        REG_WEIGHT_EVEN: weight_even <= cfg_data[15:0];
        REG_WEIGHT_ODD:  weight_odd  <= cfg_data[15:0];
        REG_BOUNDARY:    boundary    <= cfg_data;
        REG_STEP_CAP:    step_cap    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective divisor, clamped to the supported range.
  logic [DIV_W-1:0] d;
  always_comb begin
    if (modulus < DIV_W'(2)) d = DIV_W'(2);
    else if (modulus > DIV_W'(MAX_MODULUS)) d = DIV_W'(MAX_MODULUS);
    else d = modulus;
  end

  // Coefficient memory with a registered read.
  logic [COEF_W-1:0] mult_mem [MAX_MODULUS];
  logic [COEF_W-1:0] add_mem  [MAX_MODULUS];
  logic [COEF_W-1:0] a_r;
  logic [COEF_W-1:0] b_r;
  logic [RES_W-1:0]  rem;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mult_mem[residue_index] <= mult_coeff;
      add_mem[residue_index]  <= add_coeff;
    end
    if (cmd.rd) begin
      a_r <= mult_mem[rem];
      b_r <= add_mem[rem];
    end
  end

  // Orbit state.
  logic [XW-1:0]           x;
  logic [XW-1:0]           exc;
  logic [SEED_W-1:0]       seed_r;
  logic signed [CTR_W-1:0] c;
  logic [CNT_W-1:0]        steps;
  logic [CNT_W-1:0]        odd;
  logic [CNT_W-1:0]        drop_at;
  logic [CNT_W-1:0]        hit_at;
  logic                    dropped;
  logic                    hit;
  logic                    done;

  // Escape test: x above 2^ESCAPE_BITS.
  logic escaped;
  assign escaped = (|x[XW-1:ESCAPE_BITS+1]) || (x[ESCAPE_BITS] && (|x[ESCAPE_BITS-1:0]));

  // Divider: four quotient bits a cycle, most significant first.
  logic [XW-1:0]    dx;
  logic [XW-1:0]    quot;
  logic [4:0]       div_cnt;
  logic [DIV_W-1:0] r_step;
  logic [3:0]       q_step;

  always_comb begin
    r_step = {1'b0, rem};
    q_step = '0;
    for (int i = 0; i < 4; i++) begin
      r_step = {r_step[DIV_W-2:0], dx[XW-1-i]};
      if (r_step >= d) begin
        r_step = r_step - d;
        q_step[3-i] = 1'b1;
      end
    end
  end

  // Multiplier: one 32-bit quotient chunk times the coefficient a cycle.
  logic [1:0]        mul_cnt;
  logic [COEF_W-1:0] carry;
  logic [XW-1:0]     nx;
  logic [COEF_W-1:0] cin;
  logic [55:0]       prod;

  assign cin  = (mul_cnt == 2'd0) ? b_r : carry;
  assign prod = 56'(quot[32*mul_cnt +: 32]) * 56'(a_r) + 56'(cin);

  // Step update terms.
  logic signed [CTR_W-1:0] c_n;
  logic signed [CTR_W-1:0] lim;
  logic                    hit_n;
  logic                    dropped_n;
  logic [CNT_W-1:0]        steps_n;

  assign c_n       = c + (x[0] ? CTR_W'($signed(weight_odd)) : CTR_W'($signed(weight_even)));
  assign lim       = -$signed({{(CTR_W-CNT_W){1'b0}}, boundary});
  assign hit_n     = hit || (c_n <= lim);
  assign dropped_n = dropped || (nx < {{(XW-SEED_W){1'b0}}, seed_r});
  assign steps_n   = steps + CNT_W'(1);

  // Height search: shifted seed against the excursion maximum.
  logic [XW+SEED_W-1:0] sh;
  logic [XW+SEED_W-1:0] sh2;
  logic [HEIGHT_W-1:0]  h;

  assign sh2 = {sh[XW+SEED_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x       <= {{(XW-SEED_W){1'b0}}, seed};
      exc     <= {{(XW-SEED_W){1'b0}}, seed};
      seed_r  <= seed;
      c       <= '0;
      steps   <= '0;
      odd     <= '0;
      drop_at <= '0;
      hit_at  <= '0;
      dropped <= 1'b0;
      hit     <= 1'b0;
      done    <= 1'b0;
    end
    if (cmd.div_init) begin
      dx      <= x;
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      dx      <= {dx[XW-5:0], 4'b0};
      quot    <= {quot[XW-5:0], q_step};
      rem     <= r_step[RES_W-1:0];
      div_cnt <= div_cnt + 5'd1;
    end
    if (cmd.rd) begin
      mul_cnt <= '0;
    end
    if (cmd.mul_step) begin
      nx      <= {prod[31:0], nx[XW-1:32]};
      carry   <= prod[55:32];
      mul_cnt <= mul_cnt + 2'd1;
    end
    if (cmd.upd) begin
      x     <= nx;
      c     <= c_n;
      steps <= steps_n;
      if (x[0]) odd <= odd + CNT_W'(1);
      if (!hit && hit_n) begin
        hit    <= 1'b1;
        hit_at <= steps_n;
      end
      if (nx > exc) exc <= nx;
      if (!dropped && dropped_n) begin
        dropped <= 1'b1;
        drop_at <= steps_n;
      end
      done <= (dropped_n && hit_n) || (steps_n >= step_cap);
    end
    if (cmd.h_init) begin
      sh <= {{XW{1'b0}}, seed_r};
      h  <= '0;
    end
    if (cmd.h_step) begin
      sh <= sh2;
      h  <= h + HEIGHT_W'(1);
    end
    if (cmd.out_load) begin
      if (dropped) outcome <= OUT_DROPPED;
      else if (escaped) outcome <= OUT_ESCAPED;
      else outcome <= OUT_CAPPED;
      drop_step    <= drop_at;
      boundary_hit <= hit;
      hit_step     <= hit_at;
      height       <= h;
      odd_count    <= odd;
      step_count   <= steps;
    end
  end

  // Status back to the controller.
  always_comb begin
    st.escaped  = escaped;
    st.done     = done;
    st.div_last = (div_cnt == 5'd31);
    st.mul_last = (mul_cnt == 2'd3);
    st.h_stop   = (h == {HEIGHT_W{1'b1}}) || (sh2 > {{SEED_W{1'b0}}, exc});
  end

endmodule

### design/gcoe_ctrl.sv
// Controller: sequences divide, table read, multiply, update and height search.
`include "generalized_collatz_orbit_engine_unit_macros.svh"
module gcoe_ctrl import gcoe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_READ, S_MUL, S_UPDATE, S_HEIGHT, S_DONE
  } state_t;

  state_t state;
  logic   in_acc;

  assign in_acc = in_valid && in_ready;

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && in_opcode == OP_RUN) begin
            state    <= S_CHECK;
            in_ready <= 1'b0;
          end
        end
        S_CHECK: begin
          if (st.done || st.escaped) state <= S_HEIGHT;
          else state <= S_DIV;
        end
        S_DIV: if (st.div_last) state <= S_READ;
        S_READ: state <= S_MUL;
        S_MUL: if (st.mul_last) state <= S_UPDATE;
        S_UPDATE: state <= S_CHECK;
        S_HEIGHT: begin
          if (st.h_stop) begin
            state     <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_acc && (in_opcode == OP_LOAD);
    cmd.init     = (state == S_IDLE) && in_acc && (in_opcode == OP_RUN);
    cmd.div_init = (state == S_CHECK) && !(st.done || st.escaped);
    cmd.h_init   = (state == S_CHECK) && (st.done || st.escaped);
    cmd.div_step = (state == S_DIV);
    cmd.rd       = (state == S_READ);
    cmd.mul_step = (state == S_MUL);
    cmd.upd      = (state == S_UPDATE);
    cmd.h_step   = (state == S_HEIGHT) && !st.h_stop;
    cmd.out_load = (state == S_HEIGHT) && st.h_stop;
  end

  `GCOE_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "request taken while a result waits")
  `GCOE_ASSERT_NEXT(a_run_starts, cmd.init, state == S_CHECK && !in_ready,
                    "run request did not start a step")
  `GCOE_ASSERT_NEXT(a_div_to_read, state == S_DIV && st.div_last, state == S_READ,
                    "divider finish not followed by table read")
  `GCOE_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid, "result not presented")

endmodule

### design/generalized_collatz_orbit_engine_unit.sv
// Top level of the generalized Collatz orbit engine.
//
//   Channel   Dir  Handshake          Content
//   in_req    in   valid/ready        opcode, residue_index, coefficients, seed
//   out_res   out  valid/ready        outcome, steps, hit, height, counts
//   cfg       in   cfg_we, no stall   cfg_index, cfg_data
//
// A load request is written to the table when it is taken and gives no result.
// Each map step runs the escape check, the divider, the table read, the
// multiplier and the update, in that order.
// A run then ends with the height search, one shift a cycle.
// Reset is synchronous; the coefficient table is not cleared.
// A new request is taken only once the previous result has been taken.
module generalized_collatz_orbit_engine_unit import gcoe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  gcoe_in_if.sink               in_req,
  gcoe_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  gcoe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_req.valid),
    .in_opcode (in_req.opcode),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  gcoe_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .residue_index (in_req.residue_index),
    .mult_coeff    (in_req.mult_coeff),
    .add_coeff     (in_req.add_coeff),
    .seed          (in_req.seed),
    .cmd           (cmd),
    .st            (st),
    .outcome       (out_res.outcome),
    .drop_step     (out_res.drop_step),
    .boundary_hit  (out_res.boundary_hit),
    .hit_step      (out_res.hit_step),
    .height        (out_res.height),
    .odd_count     (out_res.odd_count),
    .step_count    (out_res.step_count)
  );

endmodule

### dv/generalized_collatz_orbit_engine_unit_tb.sv
// Self-checking testbench for the generalized Collatz orbit engine.
`timescale 1ns / 100ps

module generalized_collatz_orbit_engine_unit_tb;
  import gcoe_pkg::*;

  typedef struct {
    logic              op;
    logic [RES_W-1:0]  idx;
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [SEED_W-1:0] seed;
  } orbit_req_t;

  typedef struct {
    logic [1:0]          outcome;
    logic [CNT_W-1:0]    drop_step;
    logic                hit;
    logic [CNT_W-1:0]    hit_step;
    logic [HEIGHT_W-1:0] height;
    logic [CNT_W-1:0]    odd_count;
    logic [CNT_W-1:0]    step_count;
  } orbit_res_t;

  typedef struct {
    orbit_req_t req;
    bit         known;
    orbit_res_t res;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gcoe_in_if  in_req_if ();
  gcoe_out_if out_res_if ();

  generalized_collatz_orbit_engine_unit dut (
    .clk(clk),
    .rst(rst),
    .in_req(in_req_if),
    .out_res(out_res_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the registers and the coefficient table.
  logic [5:0]         modulus_sh;
  logic signed [15:0] w_even_sh;
  logic signed [15:0] w_odd_sh;
  logic [31:0]        boundary_sh;
  logic [31:0]        cap_sh;
  logic [COEF_W-1:0]  mult_tab [MAX_MODULUS];
  logic [COEF_W-1:0]  off_tab [MAX_MODULUS];

  orbit_res_t pending_orbits[$];
  bit         any_fail;
  int         results_seen;
  bit         long_hold_done;
  bit         steady;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Exact orbit of one seed under the current registers and table.
  function automatic orbit_res_t predict_orbit(logic [SEED_W-1:0] seed);
    logic [127:0] x, exc, sw, q, bound;
    logic [4:0] r;
    int unsigned dv;
    longint c, lim;
    longint unsigned steps, odd, drop_at, hit_at, cap;
    bit dropped, hit;
    int h;
    orbit_res_t res;
    dv = (modulus_sh < 2) ? 2 : (modulus_sh > MAX_MODULUS) ? MAX_MODULUS : modulus_sh;
    cap = {32'd0, cap_sh};
    lim = -longint'({32'd0, boundary_sh});
    bound = 128'd1 << ESCAPE_BITS;
    sw = {64'd0, seed};
    x = sw;
    exc = sw;
    c = 0;
    steps = 0;
    odd = 0;
    drop_at = 0;
    hit_at = 0;
    dropped = 0;
    hit = 0;
    forever begin
      if (x > bound) break;
      q = x / 128'(dv);
      r = 5'(x % 128'(dv));
      if (x[0]) odd++;
      c += x[0] ? longint'(w_odd_sh) : longint'(w_even_sh);
      if (!hit && c <= lim) begin
        hit = 1;
        hit_at = steps + 1;
      end
      x = {104'd0, mult_tab[r]} * q + {104'd0, off_tab[r]};
      steps++;
      if (x > exc) exc = x;
      if (!dropped && x < sw) begin
        dropped = 1;
        drop_at = steps;
      end
      if (dropped && hit) break;
      if (steps >= cap) break;
    end
    res.outcome = dropped ? OUT_DROPPED : (x > bound) ? OUT_ESCAPED : OUT_CAPPED;
    // Height search: largest shift of the seed that stays within the peak.
    if (seed == 0) begin
      h = 127;
    end else begin
      h = 0;
      while (h < 127 && (({192'd0, seed} << (h + 1)) <= {128'd0, exc})) h++;
    end
    res.drop_step = drop_at[31:0];
    res.hit = hit;
    res.hit_step = hit_at[31:0];
    res.height = h[6:0];
    res.odd_count = odd[31:0];
    res.step_count = steps[31:0];
    return res;
  endfunction

  // Register write, mirrored in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS:     modulus_sh = val[5:0];
      REG_WEIGHT_EVEN: w_even_sh = val[15:0];
      REG_WEIGHT_ODD:  w_odd_sh = val[15:0];
      REG_BOUNDARY:    boundary_sh = val;
      REG_STEP_CAP:    cap_sh = val;
      default: ;
    endcase
  endtask

  // Waits for the block to drain, then programs every register.
  task automatic set_regs(logic [31:0] m, logic [31:0] we, logic [31:0] wo,
                          logic [31:0] bnd, logic [31:0] cap);
    in_req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_orbits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(REG_MODULUS, m);
    write_reg(REG_WEIGHT_EVEN, we);
    write_reg(REG_WEIGHT_ODD, wo);
    write_reg(REG_BOUNDARY, bnd);
    write_reg(REG_STEP_CAP, cap);
  endtask

  // Offers one request from a rising edge and returns at the edge that takes it.
  task automatic send_req(orbit_req_t rq, bit known, orbit_res_t kres);
    in_req_if.valid <= 1'b1;
    in_req_if.opcode <= rq.op;
    in_req_if.residue_index <= rq.idx;
    in_req_if.mult_coeff <= rq.a;
    in_req_if.add_coeff <= rq.b;
    in_req_if.seed <= rq.seed;
    do @(negedge clk); while (!in_req_if.ready);
    @(posedge clk);
    if (rq.op == OP_LOAD) begin
      mult_tab[rq.idx] = rq.a;
      off_tab[rq.idx] = rq.b;
    end else begin
      pending_orbits.push_back(known ? kres : predict_orbit(rq.seed));
    end
  endtask

  // Random gap between requests: mostly none or short, sometimes long.
  task automatic sender_gap();
    int pick;
    pick = $urandom_range(0, 15);
    if (steady || pick < 8) return;
    in_req_if.valid <= 1'b0;
    repeat (pick < 14 ? $urandom_range(1, 3) : $urandom_range(20, 80)) @(posedge clk);
  endtask

  function automatic orbit_req_t rand_req(bit big, bit loads_only);
    orbit_req_t rq;
    int pick;
    rq.op = (loads_only || $urandom_range(0, 3) == 0) ? OP_LOAD : OP_RUN;
    rq.idx = RES_W'($urandom_range(0, 31));
    if (big) begin
      rq.a = COEF_W'($urandom_range(24'h800000, 24'hFFFFFF));
      rq.b = COEF_W'($urandom_range(24'h100000, 24'hFFFFFF));
    end else if ($urandom_range(0, 1)) begin
      rq.a = COEF_W'($urandom_range(0, 7));
      rq.b = COEF_W'($urandom_range(0, 7));
    end else begin
      rq.a = COEF_W'($urandom);
      rq.b = COEF_W'($urandom);
    end
    pick = $urandom_range(0, 2);
    if (pick == 0) rq.seed = SEED_W'($urandom_range(0, 1000));
    else if (pick == 1) rq.seed = {$urandom, $urandom};
    else rq.seed = {$urandom, $urandom} >> $urandom_range(1, 63);
    return rq;
  endfunction

  task automatic random_phase(int n, bit big);
    orbit_res_t none;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      send_req(rand_req(big, 0), 0, none);
      sender_gap();
    end
  endtask

  // Directed requests; expected results typed in only where obvious.
  dir_row_t dir_rows[] = '{
    '{'{OP_LOAD, 5'd0, 24'd1, 24'd0, 64'd0}, 0, '{default: '0}},
    '{'{OP_LOAD, 5'd1, 24'd6, 24'd4, 64'd0}, 0, '{default: '0}},
    '{'{OP_RUN, 5'd0, 24'd0, 24'd0, 64'd2}, 1,
      '{OUT_DROPPED, 32'd1, 1'b0, 32'd0, 7'd1, 32'd1, 32'd4}},
    '{'{OP_RUN, 5'd0, 24'd0, 24'd0, 64'd0}, 1,
      '{OUT_CAPPED, 32'd0, 1'b0, 32'd0, 7'd127, 32'd0, 32'd4}},
    '{'{OP_RUN, 5'd0, 24'd0, 24'd0, 64'd1}, 0, '{default: '0}},
    '{'{OP_RUN, 5'd0, 24'd0, 24'd0, 64'd27}, 0, '{default: '0}},
    '{'{OP_RUN, 5'd0, 24'd0, 24'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 0, '{default: '0}},
    '{'{OP_RUN, 5'd0, 24'd0, 24'd0, 64'h8000_0000_0000_0000}, 0, '{default: '0}},
    '{'{OP_LOAD, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 64'd0}, 0, '{default: '0}},
    '{'{OP_LOAD, 5'd2, 24'd0, 24'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 0, '{default: '0}},
    '{'{OP_LOAD, 5'd3, 24'hFFFFFF, 24'd0, 64'd0}, 0, '{default: '0}},
    '{'{OP_LOAD, 5'd4, 24'd0, 24'hFFFFFF, 64'd0}, 0, '{default: '0}}
  };

  // Request side: directed part, then phases of random requests.
  initial begin
    orbit_res_t none;
    none = '{default: '0};
    steady = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODULUS;
    cfg_data <= '0;
    in_req_if.valid <= 1'b0;
    in_req_if.opcode <= OP_LOAD;
    in_req_if.residue_index <= '0;
    in_req_if.mult_coeff <= '0;
    in_req_if.add_coeff <= '0;
    in_req_if.seed <= '0;
    modulus_sh = 6'd2;
    w_even_sh = 16'sd2;
    w_odd_sh = -16'sd1;
    boundary_sh = 32'd1;
    cap_sh = 32'd1000000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_STEP_CAP, 32'd4);
    // Every table entry gets a value before any run reads it.
    for (int i = 0; i < MAX_MODULUS; i++) begin
      orbit_req_t rq;
      rq = rand_req(0, 1);
      rq.idx = RES_W'(i);
      send_req(rq, 0, none);
    end
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
      sender_gap();
    end
    set_regs(32'd0, 32'h8000, 32'h7FFF, 32'd0, 32'd0);
    random_phase(10, 0);
    set_regs(32'd63, 32'h7FFF, 32'h8000, 32'hFFFF_FFFF, 32'd20);
    random_phase(10, 0);
    set_regs(32'd1, $urandom, $urandom, $urandom, 32'd50);
    random_phase(4, 0);
    // Hold back until the block has delivered everything.
    in_req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_orbits.size() != 0) @(posedge clk);
    @(posedge clk);
    random_phase(6, 0);
    // Largest step cap: large coefficients make every orbit escape quickly.
    set_regs(32'd8, -32'sd3, 32'd5, 32'd100, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      orbit_req_t rq;
      rq = rand_req(1, 1);
      rq.idx = RES_W'(i);
      send_req(rq, 0, none);
    end
    random_phase(8, 1);
    set_regs($urandom_range(2, 32), $urandom, $urandom, $urandom_range(0, 1000),
             $urandom_range(1, 64));
    steady = 1;
    random_phase(8, 0);
    steady = 0;
    set_regs($urandom_range(2, 32), $urandom, $urandom, $urandom_range(0, 1000),
             $urandom_range(1, 64));
    random_phase(8, 0);
    in_req_if.valid <= 1'b0;
    while (pending_orbits.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!any_fail) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls and one long hold-off.
  initial begin
    int pick;
    out_res_if.ready <= 1'b0;
    long_hold_done = 0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= 15) begin
        long_hold_done = 1;
        out_res_if.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      pick = $urandom_range(0, 15);
      if (steady || pick < 10) begin
        out_res_if.ready <= 1'b1;
      end else begin
        out_res_if.ready <= 1'b0;
        repeat (pick < 15 ? $urandom_range(1, 4) : $urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expected orbit.
  always @(negedge clk) begin
    orbit_res_t e;
    if (!rst && out_res_if.valid && out_res_if.ready) begin
      results_seen++;
      if (pending_orbits.size() == 0) begin
        $error("result with no request outstanding");
        any_fail = 1;
      end else begin
        e = pending_orbits.pop_front();
        if (out_res_if.outcome !== e.outcome) begin
          $error("outcome expected %0d got %0d", e.outcome, out_res_if.outcome);
          any_fail = 1;
        end
        if (out_res_if.drop_step !== e.drop_step) begin
          $error("drop_step expected %0d got %0d", e.drop_step, out_res_if.drop_step);
          any_fail = 1;
        end
        if (out_res_if.boundary_hit !== e.hit) begin
          $error("boundary_hit expected %0d got %0d", e.hit, out_res_if.boundary_hit);
          any_fail = 1;
        end
        if (out_res_if.hit_step !== e.hit_step) begin
          $error("hit_step expected %0d got %0d", e.hit_step, out_res_if.hit_step);
          any_fail = 1;
        end
        if (out_res_if.height !== e.height) begin
          $error("height expected %0d got %0d", e.height, out_res_if.height);
          any_fail = 1;
        end
        if (out_res_if.odd_count !== e.odd_count) begin
          $error("odd_count expected %0d got %0d", e.odd_count, out_res_if.odd_count);
          any_fail = 1;
        end
        if (out_res_if.step_count !== e.step_count) begin
          $error("step_count expected %0d got %0d", e.step_count, out_res_if.step_count);
          any_fail = 1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
